// File: sv/chb_pkg.sv
`timescale 1ns / 1ps
package chb_pkg;

  localparam int A_BINS     = 32;
  localparam int B_BINS     = 32;
  localparam int COUNT_BITS = 16;

  localparam int NUM_BINS = A_BINS * B_BINS;
  localparam int IDX_W    = $clog2(NUM_BINS);
  localparam int IA_W     = $clog2(A_BINS);
  localparam int IB_W     = $clog2(B_BINS);
  localparam int DQ_W     = (IA_W > IB_W) ? IA_W : IB_W;
  localparam int NUM_W    = 13 + DQ_W;

  localparam int VAL_W     = 12;
  localparam int CMD_W     = 3;
  localparam int REF_W     = 16;
  localparam int RES_W     = 26;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOTAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CMP   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_BIN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COEF  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_HIGH = 2'd3;

  localparam logic [RES_W-1:0] MAX26   = '1;
  localparam logic [RES_W-1:0] Q16_ONE = 26'd65536;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
    logic [REF_W-1:0]        reference_count;
    logic                    last_bin;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [RES_W-1:0]  result_value;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             hit;
    logic [IDX_W-1:0] bin;
    logic [REF_W-1:0] ref_count;
    logic             last;
  } work_t;

endpackage

// File: sv/chb_front.sv
`timescale 1ns / 1ps
module chb_front import chb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  input  logic                 hold_i,
  output logic                 push_o,
  output work_t                push_data_o,
  input  logic                 full_i
);

  localparam int CW = $clog2(DQ_W + 1);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_DIV_A = 2'd1;
  localparam logic [1:0] F_DIV_B = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  logic [1:0] state_q, state_d;
  logic signed [VAL_W-1:0] a_low_q, a_high_q, b_low_q, b_high_q;
  work_t item_q, item_d;
  logic [NUM_W-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [DQ_W-1:0] quo_q, quo_d, quo_nx;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IA_W-1:0] ia_q, ia_d;
  logic [VAL_W-1:0] bdiff_q, bdiff_d;

  logic signed [VAL_W:0] a_rng, b_rng, a_diff, b_diff;
  logic in_a, in_b, accept, ge;

  assign a_rng  = {a_high_q[VAL_W-1], a_high_q} - {a_low_q[VAL_W-1], a_low_q};
  assign b_rng  = {b_high_q[VAL_W-1], b_high_q} - {b_low_q[VAL_W-1], b_low_q};
  assign a_diff = {in_data_i.a_value[VAL_W-1], in_data_i.a_value}
                  - {a_low_q[VAL_W-1], a_low_q};
  assign b_diff = {in_data_i.b_value[VAL_W-1], in_data_i.b_value}
                  - {b_low_q[VAL_W-1], b_low_q};

  assign in_a = ($signed(in_data_i.a_value) >= $signed(a_low_q)) &&
                ($signed(in_data_i.a_value) <  $signed(a_high_q));
  assign in_b = ($signed(in_data_i.b_value) >= $signed(b_low_q)) &&
                ($signed(in_data_i.b_value) <  $signed(b_high_q));

  assign in_ready_o  = (state_q == F_IDLE) && !hold_i;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_data_o = item_q;

  assign ge     = (rem_q >= dv_q);
  assign quo_nx = DQ_W'({quo_q, ge});

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    rem_d   = rem_q;
    dv_d    = dv_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    ia_d    = ia_q;
    bdiff_d = bdiff_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_d.command   = in_data_i.command;
          item_d.hit       = 1'b0;
          item_d.bin       = '0;
          item_d.ref_count = in_data_i.reference_count;
          item_d.last      = in_data_i.last_bin;
          case (in_data_i.command)
            CMD_ADD, CMD_QUERY: begin
              if (in_a && in_b) begin
                item_d.hit = 1'b1;
                rem_d   = NUM_W'(a_diff[VAL_W-1:0]) * NUM_W'(A_BINS);
                dv_d    = NUM_W'(a_rng) << (DQ_W - 1);
                bdiff_d = b_diff[VAL_W-1:0];
                quo_d   = '0;
                cnt_d   = CW'(DQ_W);
                state_d = F_DIV_A;
              end else begin
                state_d = F_PUSH;
              end
            end
            CMD_CLEAR, CMD_TOTAL, CMD_CMP: state_d = F_PUSH;
            default: state_d = F_IDLE;
          endcase
        end
      end
      F_DIV_A: begin
        rem_d = ge ? rem_q - dv_q : rem_q;
        dv_d  = dv_q >> 1;
        quo_d = quo_nx;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          ia_d    = IA_W'(quo_nx);
          rem_d   = NUM_W'(bdiff_q) * NUM_W'(B_BINS);
          dv_d    = NUM_W'(b_rng) << (DQ_W - 1);
          quo_d   = '0;
          cnt_d   = CW'(DQ_W);
          state_d = F_DIV_B;
        end
      end
      F_DIV_B: begin
        rem_d = ge ? rem_q - dv_q : rem_q;
        dv_d  = dv_q >> 1;
        quo_d = quo_nx;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          item_d.bin = IDX_W'(IDX_W'(ia_q) * IDX_W'(B_BINS) + IDX_W'(quo_nx));
          state_d    = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      a_low_q  <= -12'sd2048;
      a_high_q <= 12'sd2047;
      b_low_q  <= -12'sd2048;
      b_high_q <= 12'sd2047;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_A_LOW:  a_low_q  <= cfg_wdata_i;
          CFG_A_HIGH: a_high_q <= cfg_wdata_i;
          CFG_B_LOW:  b_low_q  <= cfg_wdata_i;
          CFG_B_HIGH: b_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    ia_q    <= ia_d;
    bdiff_q <= bdiff_d;
  end

endmodule

// File: sv/chb_fifo.sv
`timescale 1ns / 1ps
module chb_fifo import chb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output work_t pop_data_o,
  output logic  empty_o
);

  work_t entry_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_q, rd_q;
  logic [FCNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == FCNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/chb_back.sv
`timescale 1ns / 1ps
module chb_back import chb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  work_t     pop_data_i,
  output logic      pop_o,
  output logic      init_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int PROD_W = COUNT_BITS + REF_W;

  localparam logic [3:0] B_CLR  = 4'd0;
  localparam logic [3:0] B_IDLE = 4'd1;
  localparam logic [3:0] B_EXEC = 4'd2;
  localparam logic [3:0] B_SQRT = 4'd3;
  localparam logic [3:0] B_ACC  = 4'd4;
  localparam logic [3:0] B_MUL  = 4'd5;
  localparam logic [3:0] B_NORM = 4'd6;
  localparam logic [3:0] B_DCHK = 4'd7;
  localparam logic [3:0] B_DIV  = 4'd8;
  localparam logic [3:0] B_RES  = 4'd9;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic [3:0] state_q, state_d;
  logic init_q, init_d;
  logic [IDX_W-1:0] clr_q, clr_d, cidx_q, cidx_d;
  work_t cur_q, cur_d;
  logic [RES_W-1:0] total_q, total_d, osum_q, osum_d, rsum_q, rsum_d;
  logic [33:0] rps_q, rps_d;
  logic [63:0] sx_q, sx_d, sr_q, sr_d, sbit_q, sbit_d, n_q, n_d, dv_q, dv_d;
  logic [51:0] mc_q, mc_d;
  logic [RES_W-1:0] mp_q, mp_d;
  logic [4:0] cnt_q, cnt_d, t_q, t_d;
  logic [16:0] quo_q, quo_d, quo_nx;
  logic fin_q, fin_d;
  out_item_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [63:0] sq_sum;
  logic        sq_ge, dv_ge;
  logic [PROD_W-1:0] prod;
  logic [33:0] osum_w, rsum_w;
  logic [34:0] rps_w;
  logic [32:0] rd_ext;

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign init_o      = init_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mem_raddr = (pop_data_i.command == CMD_CMP) ? cidx_q : pop_data_i.bin;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign sq_sum = sr_q + sbit_q;
  assign sq_ge  = (sx_q >= sq_sum);
  assign dv_ge  = (n_q >= dv_q);
  assign quo_nx = {quo_q[15:0], dv_ge};
  assign prod   = PROD_W'(rd_q) * PROD_W'(cur_q.ref_count);
  assign osum_w = 34'(osum_q) + 34'(rd_q);
  assign rsum_w = 34'(rsum_q) + 34'(cur_q.ref_count);
  assign rps_w  = 35'(rps_q) + 35'(sr_q[31:0]);
  assign rd_ext = 33'(rd_q);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    clr_d       = clr_q;
    cidx_d      = cidx_q;
    cur_d       = cur_q;
    total_d     = total_q;
    osum_d      = osum_q;
    rsum_d      = rsum_q;
    rps_d       = rps_q;
    sx_d        = sx_q;
    sr_d        = sr_q;
    sbit_d      = sbit_q;
    n_d         = n_q;
    dv_d        = dv_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    quo_d       = quo_q;
    fin_d       = fin_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q.bin;
    mem_wdata   = rd_q + COUNT_BITS'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      B_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(NUM_BINS - 1)) begin
          clr_d   = '0;
          init_d  = 1'b0;
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          cur_d = pop_data_i;
          case (pop_data_i.command)
            CMD_ADD: state_d = pop_data_i.hit ? B_EXEC : B_IDLE;
            CMD_QUERY: begin
              if (pop_data_i.hit) begin
                state_d = B_EXEC;
              end else begin
                res_d   = '{result_kind: KIND_BIN, result_value: '0};
                state_d = B_RES;
              end
            end
            CMD_CLEAR: begin
              total_d = '0;
              clr_d   = '0;
              state_d = B_CLR;
            end
            CMD_TOTAL: begin
              res_d   = '{result_kind: KIND_TOTAL, result_value: total_q};
              state_d = B_RES;
            end
            CMD_CMP: state_d = B_EXEC;
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_EXEC: begin
        case (cur_q.command)
          CMD_ADD: begin
            if (rd_q != '1) begin
              mem_we = 1'b1;
              if (total_q != MAX26) begin
                total_d = total_q + RES_W'(1);
              end
            end
            state_d = B_IDLE;
          end
          CMD_QUERY: begin
            res_d.result_kind  = KIND_BIN;
            res_d.result_value = (rd_ext > 33'(MAX26)) ? MAX26 : rd_ext[RES_W-1:0];
            state_d = B_RES;
          end
          default: begin
            sx_d   = 64'(prod) << 16;
            sr_d   = '0;
            sbit_d = 64'd1 << 62;
            fin_d  = 1'b0;
            osum_d = (osum_w > 34'(MAX26)) ? MAX26 : osum_w[RES_W-1:0];
            rsum_d = (rsum_w > 34'(MAX26)) ? MAX26 : rsum_w[RES_W-1:0];
            cidx_d = (cidx_q == IDX_W'(NUM_BINS - 1)) ? '0 : cidx_q + IDX_W'(1);
            state_d = B_SQRT;
          end
        endcase
      end
      B_SQRT: begin
        // one result bit per cycle, two radicand bits consumed
        if (sq_ge) begin
          sx_d = sx_q - sq_sum;
          sr_d = (sr_q >> 1) + sbit_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          state_d = fin_q ? B_DCHK : B_ACC;
        end
      end
      B_ACC: begin
        rps_d = (rps_w > 35'h3_FFFF_FFFF) ? '1 : rps_w[33:0];
        if (!cur_q.last) begin
          state_d = B_IDLE;
        end else if (osum_q == '0 || rsum_q == '0) begin
          res_d   = '{result_kind: KIND_COEF, result_value: Q16_ONE};
          cidx_d  = '0;
          rps_d   = '0;
          osum_d  = '0;
          rsum_d  = '0;
          state_d = B_RES;
        end else begin
          mc_d    = 52'(osum_q);
          mp_d    = rsum_q;
          sx_d    = '0;
          cnt_d   = 5'd26;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        if (mp_q[0]) begin
          sx_d = sx_q + 64'(mc_q);
        end
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          n_d     = 64'(rps_q) << 8;
          t_d     = '0;
          state_d = B_NORM;
        end
      end
      B_NORM: begin
        // scale the product up while it still fits 64 bits, at most 20 steps
        if (t_q != 5'd20 && sx_q[63:62] == 2'b00) begin
          sx_d = sx_q << 2;
          n_d  = n_q << 1;
          t_d  = t_q + 5'd1;
        end else begin
          sr_d    = '0;
          sbit_d  = 64'd1 << 62;
          fin_d   = 1'b1;
          state_d = B_SQRT;
        end
      end
      B_DCHK: begin
        if (sr_q == '0 || n_q >= (sr_q << 17)) begin
          res_d   = '{result_kind: KIND_COEF, result_value: Q16_ONE};
          cidx_d  = '0;
          rps_d   = '0;
          osum_d  = '0;
          rsum_d  = '0;
          state_d = B_RES;
        end else begin
          dv_d    = sr_q << 16;
          quo_d   = '0;
          cnt_d   = 5'd17;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (dv_ge) begin
          n_d = n_q - dv_q;
        end
        dv_d  = dv_q >> 1;
        quo_d = quo_nx;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          res_d.result_kind  = KIND_COEF;
          res_d.result_value = (RES_W'(quo_nx) > Q16_ONE) ? Q16_ONE : RES_W'(quo_nx);
          cidx_d  = '0;
          rps_d   = '0;
          osum_d  = '0;
          rsum_d  = '0;
          state_d = B_RES;
        end
      end
      B_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      cidx_q      <= '0;
      total_q     <= '0;
      osum_q      <= '0;
      rsum_q      <= '0;
      rps_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      cidx_q      <= cidx_d;
      total_q     <= total_d;
      osum_q      <= osum_d;
      rsum_q      <= rsum_d;
      rps_q       <= rps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    sx_q   <= sx_d;
    sr_q   <= sr_d;
    sbit_q <= sbit_d;
    n_q    <= n_d;
    dv_q   <= dv_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    cnt_q  <= cnt_d;
    t_q    <= t_d;
    quo_q  <= quo_d;
    fin_q  <= fin_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

// File: sv/chroma_histogram_bhattacharyya.sv
`timescale 1ns / 1ps
// channel    direction  handshake                 payload
// in         input      in_valid_i / in_ready_o   in_data_i (in_item_t)
// out        output     out_valid_o / out_ready_i out_data_o (out_item_t)
// cfg        input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// front: an add or query inside both ranges finds its bin with the one-bit-per-cycle
// bin divider, a axis then b axis; other requests go straight to the push state.
// back: a compare bin runs a 32-step square root; the last bin adds a product,
// scaling, a second root and a divide.
// after reset the bin memory is swept with in_ready_o low, a clear
// request sweeps it too; a 2-entry queue lets the front run while the back stalls.
module chroma_histogram_bhattacharyya import chb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  logic  push, full, pop, empty, init;
  work_t push_data, pop_data;

  chb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .hold_i      (init),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  chb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  chb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .init_o      (init),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
